### src/glj_pkg.sv
package glj_pkg;

    localparam int unsigned MAX_LINE_WIDTH = 255;
    localparam int unsigned WIDTH_BITS     = 8;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 8'd80;
    localparam logic [7:0] MAX_COUNT = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACK,
        ST_CLOSE,
        ST_DIV,
        ST_SEND,
        ST_LAST
    } t_state;

    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
        logic [7:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic [7:0] word_count;
        logic [7:0] base_gap;
        logic [6:0] long_gaps;
        logic [7:0] trailing_pad;
        logic       final_line;
        logic       overflow;
        logic       run_end;
    } t_rec;

endpackage

### src/glj_div.sv
module glj_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  glj_pkg::t_div_req i_req,
    output glj_pkg::t_div_rsp o_rsp
);

    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] r_num, n_num;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_den, n_den;
    logic [8:0] trial;
    logic       take;

    // one restoring step per cycle, quotient bits shift into r_num
    assign trial = {r_rem, r_num[7]};
    assign take  = (trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_num  = i_req.dividend;
            n_rem  = 8'd0;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = take ? 8'(trial - {1'b0, r_den}) : trial[7:0];
            n_num = {r_num[6:0], take};
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

endmodule

### src/greedy_line_justifier.sv
// greedy line justifier: packs word lengths into lines and emits layout records
//
// input channel: i_valid, i_word_length, i_last_word; o_stall high while busy.
// output channel: o_valid with the record fields; i_stall from the receiver.
// config: i_cfg_we with i_cfg_data writes the line width (reset 80) at the
// edge; write it only while no beat is in flight.
// one item is taken at a time. closing a line of several words runs the 8-step
// restoring divider (slack by gaps) before the record is offered; the next beat
// is taken only once that record has left on a low i_stall. a last word that
// also closes such a line then sends a second, final record. records that skip
// the divider are the single-word, final and blank ones. the block takes no new
// item until it is through with the last one.
// while i_stall is high the record holds on the outputs and the block waits;
// nothing is dropped. records for one item come out in order, run_end on the
// last one.
// reset (synchronous, active low) clears the open line, the emitted flag and
// the sequencer, and sets the width back to 80.
module greedy_line_justifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_word_length,
    input  logic       i_last_word,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_word_count,
    output logic [7:0] o_base_gap,
    output logic [6:0] o_long_gaps,
    output logic [7:0] o_trailing_pad,
    output logic       o_final_line,
    output logic       o_overflow,
    output logic       o_run_end
);

    glj_pkg::t_state r_state, n_state;
    logic [7:0] r_width, n_width;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_len, n_len;
    logic       r_any, n_any;
    logic [7:0] r_wl, n_wl;
    logic       r_last, n_last;
    logic       r_final, n_final;
    glj_pkg::t_rec r_rec, n_rec;

    glj_pkg::t_div_req div_req;
    glj_pkg::t_div_rsp div_rsp;

    logic [9:0] sum;
    logic       fits;
    logic       need_close;
    logic [7:0] slack;
    logic       ovf;
    logic       use_div;

    glj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign sum  = {2'b00, r_len} + {2'b00, r_wl} + 10'd1;
    assign fits = (sum <= {2'b00, r_width}) && (r_cnt != glj_pkg::MAX_COUNT);
    assign need_close = (r_wl != 8'd0) && (r_cnt != 8'd0) && !fits;

    assign slack   = (r_len < r_width) ? 8'(r_width - r_len) : 8'd0;
    assign ovf     = (r_len > r_width);
    assign use_div = (r_cnt != 8'd1) && !r_final;

    always_comb begin
        n_state = r_state;
        case (r_state)
            glj_pkg::ST_IDLE:  if (i_valid) n_state = glj_pkg::ST_PACK;
            glj_pkg::ST_PACK:  n_state = need_close ? glj_pkg::ST_CLOSE : glj_pkg::ST_LAST;
            glj_pkg::ST_CLOSE: n_state = use_div ? glj_pkg::ST_DIV : glj_pkg::ST_SEND;
            glj_pkg::ST_DIV:   if (div_rsp.done) n_state = glj_pkg::ST_SEND;
            glj_pkg::ST_SEND: begin
                if (!i_stall) n_state = r_final ? glj_pkg::ST_IDLE : glj_pkg::ST_LAST;
            end
            glj_pkg::ST_LAST: begin
                if (!r_last) n_state = glj_pkg::ST_IDLE;
                else if (r_cnt != 8'd0) n_state = glj_pkg::ST_CLOSE;
                else if (!r_any) n_state = glj_pkg::ST_SEND;
                else n_state = glj_pkg::ST_IDLE;
            end
            default: n_state = glj_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_width = r_width;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_any   = r_any;
        n_wl    = r_wl;
        n_last  = r_last;
        n_final = r_final;
        n_rec   = r_rec;
        div_req.start    = 1'b0;
        div_req.dividend = slack;
        div_req.divisor  = 8'(r_cnt - 8'd1);
        if (i_cfg_we) n_width = i_cfg_data;
        case (r_state)
            glj_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_wl    = i_word_length;
                    n_last  = i_last_word;
                    n_final = 1'b0;
                end
            end
            glj_pkg::ST_PACK: begin
                if (r_wl != 8'd0 && !need_close) begin
                    if (r_cnt == 8'd0) begin
                        n_cnt = 8'd1;
                        n_len = r_wl;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                        n_len = sum[7:0];
                    end
                end
            end
            glj_pkg::ST_CLOSE: begin
                n_rec.word_count   = r_cnt;
                n_rec.long_gaps    = 7'd0;
                n_rec.final_line   = r_final;
                n_rec.overflow     = ovf;
                n_rec.run_end      = r_final || !r_last;
                if (r_cnt == 8'd1) begin
                    n_rec.base_gap     = 8'd0;
                    n_rec.trailing_pad = slack;
                end else if (r_final) begin
                    n_rec.base_gap     = 8'd1;
                    n_rec.trailing_pad = slack;
                end else begin
                    n_rec.trailing_pad = 8'd0;
                    div_req.start      = 1'b1;
                end
            end
            glj_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_rec.base_gap  = 8'(div_rsp.quot + 8'd1);
                    n_rec.long_gaps = div_rsp.rem[6:0];
                end
            end
            glj_pkg::ST_SEND: begin
                if (!i_stall) begin
                    if (r_final) begin
                        n_cnt = 8'd0;
                        n_len = 8'd0;
                        n_any = 1'b0;
                    end else begin
                        // closed line is out, the word that broke it opens the next
                        n_cnt = 8'd1;
                        n_len = r_wl;
                        n_any = 1'b1;
                    end
                end
            end
            glj_pkg::ST_LAST: begin
                if (r_last) begin
                    n_final = 1'b1;
                    if (r_cnt == 8'd0) begin
                        if (!r_any) begin
                            n_rec.word_count   = 8'd0;
                            n_rec.base_gap     = 8'd0;
                            n_rec.long_gaps    = 7'd0;
                            n_rec.trailing_pad = r_width;
                            n_rec.final_line   = 1'b1;
                            n_rec.overflow     = 1'b0;
                            n_rec.run_end      = 1'b1;
                        end else begin
                            n_any = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glj_pkg::ST_IDLE;
            r_width <= glj_pkg::WIDTH_RESET;
            r_cnt   <= 8'd0;
            r_len   <= 8'd0;
            r_any   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_width <= n_width;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_any   <= n_any;
            r_final <= n_final;
        end
        r_wl   <= n_wl;
        r_last <= n_last;
        r_rec  <= n_rec;
    end

    assign o_stall        = (r_state != glj_pkg::ST_IDLE);
    assign o_valid        = (r_state == glj_pkg::ST_SEND);
    assign o_word_count   = r_rec.word_count;
    assign o_base_gap     = r_rec.base_gap;
    assign o_long_gaps    = r_rec.long_gaps;
    assign o_trailing_pad = r_rec.trailing_pad;
    assign o_final_line   = r_rec.final_line;
    assign o_overflow     = r_rec.overflow;
    assign o_run_end      = r_rec.run_end;

endmodule
